@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_ALW(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/zpic_pkg.sv @@
`default_nettype none

package zpic_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int KERNEL_MAX  = 5;
    localparam int TAPS        = KERNEL_MAX * KERNEL_MAX;
    localparam int STACK_DEPTH = KERNEL_MAX - 1;
    localparam int RADIUS_MAX  = (KERNEL_MAX - 1) / 2;

    localparam int PIX_W      = 16;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int DIM_W      = 11;
    localparam int RAD_W      = 2;
    localparam int TAP_IDX_W  = 5;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int LAT_W      = DIM_W + 1;
    localparam int PROD_W     = 2 * PIX_W;
    localparam int GROUP_W    = PROD_W + $clog2(KERNEL_MAX);
    localparam int SUM_W      = PROD_W + $clog2(TAPS);
    localparam int FRAC_SHIFT = 15;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int IN_USED_W   = 2 * PIX_W + TAP_IDX_W;
    localparam int OUT_USED_W  = PIX_W + COL_W + ROW_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_TAP   = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_FLUSH = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_RADIUS = 2'd2
    } t_cfg_idx;

    typedef logic signed [PIX_W-1:0] t_pix;
    typedef logic [STACK_DEPTH*PIX_W-1:0] t_stack;

    // Position tag of an output pixel, carried down the pipeline.
    typedef struct packed {
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_pos;

endpackage

`default_nettype wire

@@ hdl/zero_padded_image_convolution.sv @@
// Same-size 2D convolution with zero padding, kernel up to 5x5, Q8.8 pixels, Q1.15 taps.
// Input stream (s side): tuser is the item kind (tap load, pixel, flush step). Taps are
// loaded first; pixels then follow in row-major order, and flush steps past the frame
// end drain the outputs still owed. Each pixel or flush request at stream position n
// yields the output pixel at position n - radius*(width+1), tagged with its column and
// row; tlast marks the final pixel of the frame, after which a new frame starts.
// Output stream (m side): one result request per emitting item, in frame order.
// Rate: one item per clock while the output is not stalled, set by the one-read one-write
// column store, which is read at accept and written back one stage later (forwarded when
// width is one pixel). Items pass stage 1, stage 2, the product, row-sum and total registers, then the output register.
// Config port: width, height and radius writes restart the frame; taps are kept.
// Reset: synchronous, active low; clears the counters and the pipeline, leaves the
// column store and taps as they are, so taps must be loaded after power-up.
// Stall: a stalled receiver holds the output register; bubbles in the pipeline still
// fill, and tready drops only once every stage ahead of the input holds a request.
`default_nettype none

module zero_padded_image_convolution (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // pixel[15:0], tap_index[20:16], tap_value[36:21], zero fill[39:37]
    input  logic [zpic_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // kind[1:0]
    input  logic [zpic_pkg::KIND_W-1:0]         i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // result[15:0], out_col[25:16], out_row[35:26], zero fill[39:36]
    output logic [zpic_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic                                o_m_tlast,
    input  logic                                i_cfg_we,
    input  logic [zpic_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [zpic_pkg::DIM_W-1:0]          i_cfg_data
);
    import zpic_pkg::*;

    localparam logic signed [SUM_W:0] SAT_HI   = (SUM_W+1)'(32767);
    localparam logic signed [SUM_W:0] SAT_LO   = -(SUM_W+1)'(32768);
    localparam logic signed [SUM_W:0] RND_HALF = (SUM_W+1)'(1) <<< (FRAC_SHIFT - 1);

    // configuration
    logic [DIM_W-1:0] r_width, r_height;
    logic [RAD_W-1:0] r_radius;

    // stream counters
    logic [COL_W-1:0] r_in_col, r_ex;
    logic [ROW_W-1:0] r_ey;
    logic [LAT_W-1:0] r_fill;

    // stage valids
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_ov;
    logic free1, free2, free3, free4, free5, ofree;

    // column store: older rows of each column
    t_stack mem [MAX_WIDTH];
    t_stack r_rd, r_wr_stack;

    // stage 1
    t_kind                r1_kind;
    t_pix                 r1_pix, r1_tval;
    logic [TAP_IDX_W-1:0] r1_tidx;
    logic [COL_W-1:0]     r1_col;
    logic                 r1_emit, r1_fwd;
    t_pos                 r1_pos;

    // stage 2
    t_kind                r2_kind;
    t_pix                 r2_tval;
    logic [TAP_IDX_W-1:0] r2_tidx;
    logic                 r2_emit;
    t_pos                 r2_pos;
    logic [TAPS-1:0]      r2_mask;

    t_pix r_win [KERNEL_MAX][KERNEL_MAX];
    t_pix r_tap [TAPS];

    logic signed [PROD_W-1:0]  r3_prod [TAPS];
    t_pos                      r3_pos;
    logic signed [GROUP_W-1:0] r4_part [KERNEL_MAX];
    t_pos                      r4_pos;
    logic signed [SUM_W-1:0]   r5_sum;
    t_pos                      r5_pos;
    t_pix                      r_out_result;
    t_pos                      r_out_pos;

    // input decode
    t_kind            in_kind;
    logic             in_stream, accept, in_emit, in_fin;
    logic [LAT_W-1:0] lat;
    logic             cfg_hit;
    logic [DIM_W-1:0] cfg_dim;
    logic [RAD_W-1:0] cfg_rad;

    // stage 1 datapath
    logic                 s1_stream, s1_write;
    t_stack               old_stack, new_stack;
    t_pix                 new_pix;
    logic [TAPS-1:0]      n_mask;
    logic [LAT_W-1:0]     ax, ay;
    logic [KERNEL_MAX-1:0] mx, my;

    logic signed [PROD_W-1:0]  n_prod [TAPS];
    logic signed [GROUP_W-1:0] n_part [KERNEL_MAX];
    logic signed [SUM_W-1:0]   n_sum;
    logic signed [SUM_W:0]     rnd, shr;
    t_pix                      n_result;

    // pipeline flow: each stage takes a request when it is empty or emptying
    assign ofree = !r_ov || i_m_tready;
    assign free5 = !r_v5 || ofree;
    assign free4 = !r_v4 || free5;
    assign free3 = !r_v3 || free4;
    assign free2 = !r_v2 || free3;
    assign free1 = !r_v1 || free2;
    assign o_s_tready = free1;

    assign in_kind   = t_kind'(i_s_tuser);
    assign in_stream = (in_kind == KIND_PIXEL) || (in_kind == KIND_FLUSH);
    assign accept    = i_s_tvalid && free1;

    always_comb begin
        case (r_radius)
            2'd0:    lat = '0;
            2'd1:    lat = {1'b0, r_width} + LAT_W'(1);
            default: lat = ({1'b0, r_width} + LAT_W'(1)) << 1;
        endcase
    end

    assign in_emit = in_stream && (r_fill >= lat);
    assign in_fin  = in_emit && ({1'b0, r_ey} == r_height - DIM_W'(1))
                     && ({1'b0, r_ex} == r_width - DIM_W'(1));

    // configuration write with saturation
    always_comb begin
        cfg_hit = 1'b0;
        cfg_dim = i_cfg_data;
        if (cfg_dim == '0) begin
            cfg_dim = DIM_W'(1);
        end else if (cfg_dim > DIM_W'(MAX_WIDTH)) begin
            cfg_dim = DIM_W'(MAX_WIDTH);
        end
        cfg_rad = i_cfg_data[RAD_W-1:0];
        if (cfg_rad > RAD_W'(RADIUS_MAX)) begin
            cfg_rad = RAD_W'(RADIUS_MAX);
        end
        case (t_cfg_idx'(i_cfg_idx))
            CFG_WIDTH, CFG_HEIGHT, CFG_RADIUS: cfg_hit = i_cfg_we;
            default:                           cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(MAX_WIDTH);
            r_height <= DIM_W'(MAX_ROWS);
            r_radius <= RAD_W'(1);
        end else if (cfg_hit) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  r_width  <= cfg_dim;
                CFG_HEIGHT: r_height <= (cfg_dim > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                                     : cfg_dim;
                CFG_RADIUS: r_radius <= cfg_rad;
                default:    r_radius <= r_radius;
            endcase
        end
    end

    // stream position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_in_col <= '0;
            r_ex     <= '0;
            r_ey     <= '0;
            r_fill   <= '0;
        end else if (accept && in_stream) begin
            if (in_fin) begin
                r_in_col <= '0;
                r_ex     <= '0;
                r_ey     <= '0;
                r_fill   <= '0;
            end else begin
                if ({1'b0, r_in_col} + DIM_W'(1) >= r_width) begin
                    r_in_col <= '0;
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
                if (in_emit) begin
                    if ({1'b0, r_ex} + DIM_W'(1) >= r_width) begin
                        r_ex <= '0;
                        r_ey <= r_ey + ROW_W'(1);
                    end else begin
                        r_ex <= r_ex + COL_W'(1);
                    end
                end else begin
                    r_fill <= r_fill + LAT_W'(1);
                end
            end
        end
    end

    // valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (free1) r_v1 <= i_s_tvalid;
            if (free2) r_v2 <= r_v1;
            if (free3) r_v3 <= r_v2 && r2_emit;
            if (free4) r_v4 <= r_v3;
            if (free5) r_v5 <= r_v4;
            if (ofree) r_ov <= r_v5;
        end
    end

    // stage 1: column store read at accept
    always_ff @(posedge i_clk) begin
        if (free1) begin
            r1_kind <= in_kind;
            r1_pix  <= i_s_tdata[PIX_W-1:0];
            r1_tidx <= i_s_tdata[PIX_W +: TAP_IDX_W];
            r1_tval <= i_s_tdata[PIX_W+TAP_IDX_W +: PIX_W];
            r1_col  <= r_in_col;
            r1_emit <= in_emit;
            r1_pos  <= '{last: in_fin, row: r_ey, col: r_ex};
            // the item ahead writes this same column at this edge
            r1_fwd  <= s1_write && (r1_col == r_in_col);
        end
    end

    assign s1_stream = (r1_kind == KIND_PIXEL) || (r1_kind == KIND_FLUSH);
    assign s1_write  = r_v1 && free2 && s1_stream;
    assign old_stack = r1_fwd ? r_wr_stack : r_rd;
    assign new_pix   = (r1_kind == KIND_PIXEL) ? r1_pix : '0;
    assign new_stack = {old_stack[(STACK_DEPTH-1)*PIX_W-1:0], new_pix};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= mem[r_in_col];
        end
        if (s1_write) begin
            mem[r1_col] <= new_stack;
            r_wr_stack  <= new_stack;
        end
    end

    // window: column 0 is the newest stream position, row k is k lines back
    always_ff @(posedge i_clk) begin
        if (s1_write) begin
            r_win[0][0] <= new_pix;
            for (int fy = 1; fy < KERNEL_MAX; fy++) begin
                r_win[0][fy] <= old_stack[(fy-1)*PIX_W +: PIX_W];
            end
            for (int fx = 1; fx < KERNEL_MAX; fx++) begin
                r_win[fx] <= r_win[fx-1];
            end
        end
    end

    // zero padding mask from the output coordinates
    always_comb begin
        ax = LAT_W'(r1_pos.col) + LAT_W'(r_radius);
        ay = LAT_W'(r1_pos.row) + LAT_W'(r_radius);
        for (int k = 0; k < KERNEL_MAX; k++) begin
            mx[k] = (LAT_W'(k) <= LAT_W'({r_radius, 1'b0})) && (ax >= LAT_W'(k))
                    && (ax < {1'b0, r_width} + LAT_W'(k));
            my[k] = (LAT_W'(k) <= LAT_W'({r_radius, 1'b0})) && (ay >= LAT_W'(k))
                    && (ay < {1'b0, r_height} + LAT_W'(k));
        end
        for (int fy = 0; fy < KERNEL_MAX; fy++) begin
            for (int fx = 0; fx < KERNEL_MAX; fx++) begin
                n_mask[fy*KERNEL_MAX+fx] = mx[fx] && my[fy];
            end
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (free2) begin
            r2_kind <= r1_kind;
            r2_tidx <= r1_tidx;
            r2_tval <= r1_tval;
            r2_emit <= r1_emit;
            r2_pos  <= r1_pos;
            r2_mask <= n_mask;
        end
    end

    // tap load lands in order with the pixels around it
    always_ff @(posedge i_clk) begin
        if (r_v2 && free3 && (r2_kind == KIND_TAP) && (r2_tidx < TAP_IDX_W'(TAPS))) begin
            r_tap[r2_tidx] <= r2_tval;
        end
    end

    always_comb begin
        for (int fy = 0; fy < KERNEL_MAX; fy++) begin
            for (int fx = 0; fx < KERNEL_MAX; fx++) begin
                n_prod[fy*KERNEL_MAX+fx] = r2_mask[fy*KERNEL_MAX+fx]
                    ? PROD_W'(r_win[fx][fy]) * PROD_W'(r_tap[fy*KERNEL_MAX+fx]) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free3) begin
            r3_prod <= n_prod;
            r3_pos  <= r2_pos;
        end
    end

    // adder tree: rows, then total
    always_comb begin
        for (int g = 0; g < KERNEL_MAX; g++) begin
            n_part[g] = '0;
            for (int k = 0; k < KERNEL_MAX; k++) begin
                n_part[g] = n_part[g] + GROUP_W'(r3_prod[g*KERNEL_MAX+k]);
            end
        end
        n_sum = '0;
        for (int g = 0; g < KERNEL_MAX; g++) begin
            n_sum = n_sum + SUM_W'(r4_part[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (free4) begin
            r4_part <= n_part;
            r4_pos  <= r3_pos;
        end
        if (free5) begin
            r5_sum <= n_sum;
            r5_pos <= r4_pos;
        end
    end

    // round half up to Q8.8 and saturate
    always_comb begin
        rnd = (SUM_W+1)'(r5_sum) + RND_HALF;
        shr = rnd >>> FRAC_SHIFT;
        if (shr > SAT_HI) begin
            n_result = t_pix'(SAT_HI);
        end else if (shr < SAT_LO) begin
            n_result = t_pix'(SAT_LO);
        end else begin
            n_result = shr[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ofree) begin
            r_out_result <= n_result;
            r_out_pos    <= r5_pos;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tlast  = r_out_pos.last;
    assign o_m_tdata  = {(OUT_TDATA_W-OUT_USED_W)'(0), r_out_pos.row, r_out_pos.col,
                         r_out_result};

endmodule

`default_nettype wire

@@ hdl/zpic_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module zpic_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    input logic [zpic_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input logic [zpic_pkg::KIND_W-1:0]         i_s_tuser,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [zpic_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input logic                                o_m_tlast,
    input logic                                i_cfg_we,
    input logic [zpic_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input logic [zpic_pkg::DIM_W-1:0]          i_cfg_data
);
    import zpic_pkg::*;

    // a held result must not change under a stalled receiver
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "output changed while stalled")

    // reset empties every stage, so input is open and output idle
    `ASSERT_ALW(a_reset_empty, i_clk, !i_rst_n, !o_m_tvalid && o_s_tready,
        "pipeline not empty after reset")

    // with the output empty, no stage can be holding back the input
    `ASSERT_IMP(a_ready_when_idle, i_clk, i_rst_n, !o_m_tvalid, o_s_tready,
        "input stalled with empty output")

    // a result straight after the frame end belongs to the next frame's origin
    `ASSERT_NXT(a_frame_restart, i_clk, i_rst_n, o_m_tvalid && i_m_tready && o_m_tlast,
        !o_m_tvalid || (o_m_tdata[OUT_USED_W-1:PIX_W] == '0), "new frame not at origin")

endmodule

bind zero_padded_image_convolution zpic_checker u_zpic_checker (.*);

`default_nettype wire
